>>> sv/iar_pkg.sv
`default_nettype none

package iar_pkg;

    // Field width of the value port; the converted width is a parameter below it
    localparam int VALUE_BITS        = 64;
    localparam int VALUE_WIDTH_DEF   = 64;

    // Decimal digits needed for any value up to 64 bits
    localparam int MAX_DIGITS        = 20;

    // Entries in the request queue between front and back
    localparam int QUEUE_DEPTH       = 2;

    localparam logic [6:0] CH_ZERO    = 7'h30;
    localparam logic [6:0] CH_UPPER_A = 7'h41;
    localparam logic [6:0] CH_LOWER_A = 7'h61;
    localparam logic [6:0] CH_MINUS   = 7'h2D;

    // Classification of one request, decided by the front
    typedef struct packed {
        logic neg;    // emit a leading minus sign
        logic hex;    // base sixteen
        logic upper;  // upper-case letters
    } t_flags;

    localparam int FLAGS_BITS = $bits(t_flags);

endpackage

`default_nettype wire

>>> sv/iar_front.sv
`default_nettype none

module iar_front
    import iar_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  wire logic [VALUE_BITS-1:0]  i_value,
    input  wire logic                   i_is_signed,
    input  wire logic                   i_radix_select,
    input  wire logic                   i_upper_case,
    output      logic [VALUE_WIDTH-1:0] o_mag,
    output      t_flags                 o_flags
);

    logic [VALUE_WIDTH-1:0] v;
    logic                   neg;

    // Drop bits above the converted width, then take the magnitude
    assign v   = i_value[VALUE_WIDTH-1:0];
    assign neg = i_is_signed & v[VALUE_WIDTH-1];

    assign o_mag         = neg ? (~v + {{(VALUE_WIDTH-1){1'b0}}, 1'b1}) : v;
    assign o_flags.neg   = neg;
    assign o_flags.hex   = i_radix_select;
    assign o_flags.upper = i_upper_case & ~i_is_signed;

endmodule

`default_nettype wire

>>> sv/iar_queue.sv
`default_nettype none

module iar_queue
    import iar_pkg::*;
#(
    parameter int DATA_W = VALUE_WIDTH_DEF + FLAGS_BITS
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire logic [DATA_W-1:0] i_wdata,
    output      logic              o_full,
    input  wire logic              i_pop,
    output      logic [DATA_W-1:0] o_rdata,
    output      logic              o_empty
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [DATA_W-1:0] r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wptr, n_wptr;
    logic [PTR_W-1:0]  r_rptr, n_rptr;
    logic [CNT_W-1:0]  r_cnt,  n_cnt;

    assign o_full  = (r_cnt == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rdata = r_mem[r_rptr];

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (i_push) begin
            n_wptr = (r_wptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

endmodule

`default_nettype wire

>>> sv/iar_back.sv
`default_nettype none

module iar_back
    import iar_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_empty,
    input  wire logic [VALUE_WIDTH-1:0] i_mag,
    input  wire t_flags                 i_flags,
    output      logic                   o_pop,
    output      logic                   o_out_valid,
    input  wire logic                   i_out_ready,
    output      logic [6:0]             o_ascii_char,
    output      logic                   o_last_char
);

    localparam int BCD_W = 4 * MAX_DIGITS;
    localparam int BIT_W = $clog2(VALUE_WIDTH);
    localparam int CNT_W = $clog2(MAX_DIGITS + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CONV = 3'd1;
    localparam logic [2:0] ST_SKIP = 3'd2;
    localparam logic [2:0] ST_SIGN = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    logic [2:0]             r_state, n_state;
    logic [BCD_W-1:0]       r_bcd,   n_bcd;
    logic [VALUE_WIDTH-1:0] r_mag,   n_mag;
    logic [BIT_W-1:0]       r_bit,   n_bit;
    logic [CNT_W-1:0]       r_cnt,   n_cnt;
    logic                   r_neg,   n_neg;
    logic                   r_upper, n_upper;
    logic                   r_ovld,  n_ovld;
    logic [6:0]             r_char,  n_char;
    logic                   r_last,  n_last;

    logic [BCD_W-1:0]       adj;
    logic [3:0]             top;
    logic                   slot_free;

    function automatic logic [6:0] digit_char(input logic [3:0] d, input logic upper);
        logic [6:0] base;
        base = upper ? CH_UPPER_A : CH_LOWER_A;
        if (d < 4'd10) begin
            digit_char = CH_ZERO + {3'b000, d};
        end else begin
            digit_char = base + {3'b000, d} - 7'd10;
        end
    endfunction

    // Add three to every BCD digit of five or more before the next shift
    always_comb begin
        for (int k = 0; k < MAX_DIGITS; k++) begin
            adj[4*k +: 4] = (r_bcd[4*k +: 4] >= 4'd5) ? r_bcd[4*k +: 4] + 4'd3
                                                      : r_bcd[4*k +: 4];
        end
    end

    assign top       = r_bcd[BCD_W-1 -: 4];
    assign slot_free = !r_ovld || i_out_ready;

    always_comb begin
        n_state = r_state;
        n_bcd   = r_bcd;
        n_mag   = r_mag;
        n_bit   = r_bit;
        n_cnt   = r_cnt;
        n_neg   = r_neg;
        n_upper = r_upper;
        n_ovld  = r_ovld && !i_out_ready;
        n_char  = r_char;
        n_last  = r_last;
        o_pop   = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_neg   = i_flags.neg;
                    n_upper = i_flags.upper;
                    n_cnt   = CNT_W'(MAX_DIGITS);
                    n_mag   = i_mag;
                    n_bit   = BIT_W'(VALUE_WIDTH - 1);
                    if (i_flags.hex) begin
                        n_bcd   = {{(BCD_W-VALUE_WIDTH){1'b0}}, i_mag};
                        n_state = ST_SKIP;
                    end else begin
                        n_bcd   = '0;
                        n_state = ST_CONV;
                    end
                end
            end
            ST_CONV: begin
                n_bcd = {adj[BCD_W-2:0], r_mag[VALUE_WIDTH-1]};
                n_mag = {r_mag[VALUE_WIDTH-2:0], 1'b0};
                n_bit = r_bit - 1'b1;
                if (r_bit == '0) begin
                    n_state = ST_SKIP;
                end
            end
            ST_SKIP: begin
                if (top == 4'd0 && r_cnt != CNT_W'(1)) begin
                    n_bcd = {r_bcd[BCD_W-5:0], 4'd0};
                    n_cnt = r_cnt - 1'b1;
                end else begin
                    n_state = r_neg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN: begin
                if (slot_free) begin
                    n_ovld  = 1'b1;
                    n_char  = CH_MINUS;
                    n_last  = 1'b0;
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (slot_free) begin
                    n_ovld = 1'b1;
                    n_char = digit_char(top, r_upper);
                    n_last = (r_cnt == CNT_W'(1));
                    n_bcd  = {r_bcd[BCD_W-5:0], 4'd0};
                    n_cnt  = r_cnt - 1'b1;
                    if (r_cnt == CNT_W'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ovld  <= n_ovld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bcd   <= n_bcd;
        r_mag   <= n_mag;
        r_bit   <= n_bit;
        r_cnt   <= n_cnt;
        r_neg   <= n_neg;
        r_upper <= n_upper;
        r_char  <= n_char;
        r_last  <= n_last;
    end

    assign o_out_valid  = r_ovld;
    assign o_ascii_char = r_char;
    assign o_last_char  = r_last;

endmodule

`default_nettype wire

>>> sv/integer_to_ascii_radix.sv
`default_nettype none

// Channel   Direction  Handshake                 Payload
// request   in         i_in_valid / o_in_ready   i_value, i_is_signed, i_radix_select, i_upper_case
// character out        o_out_valid / i_out_ready o_ascii_char, o_last_char
//
// Each request leaves the queue, then runs through bit-serial double dabble over all
// VALUE_WIDTH bits when decimal (hex loads its nibbles at once), then drops leading
// zeros (at most MAX_DIGITS-1), then emits its characters, minus sign included,
// while the output register is free.
// Reset (synchronous, active low) empties the request queue and the output register.
// The two-entry queue keeps accepting requests while the back end converts or the
// character sink stalls; o_in_ready falls only when the queue is full.

module integer_to_ascii_radix
    import iar_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output      logic                  o_in_ready,
    input  wire logic [VALUE_BITS-1:0] i_value,
    input  wire logic                  i_is_signed,
    input  wire logic                  i_radix_select,
    input  wire logic                  i_upper_case,
    output      logic                  o_out_valid,
    input  wire logic                  i_out_ready,
    output      logic [6:0]            o_ascii_char,
    output      logic                  o_last_char
);

    localparam int Q_W = VALUE_WIDTH + FLAGS_BITS;

    logic [VALUE_WIDTH-1:0] front_mag;
    t_flags                 front_flags;
    logic                   q_full;
    logic                   q_empty;
    logic                   q_pop;
    logic [Q_W-1:0]         q_rdata;
    logic                   push;
    t_flags                 back_flags;

    // Classify the request: mask to width, take magnitude, pick letter case
    iar_front #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .i_value        (i_value),
        .i_is_signed    (i_is_signed),
        .i_radix_select (i_radix_select),
        .i_upper_case   (i_upper_case),
        .o_mag          (front_mag),
        .o_flags        (front_flags)
    );

    // Accept whenever the queue has room
    assign o_in_ready = !q_full;
    assign push       = i_in_valid && !q_full;

    iar_queue #(
        .DATA_W (Q_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata ({front_flags, front_mag}),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_rdata (q_rdata),
        .o_empty (q_empty)
    );

    assign back_flags = t_flags'(q_rdata[Q_W-1:VALUE_WIDTH]);

    // Convert and stream characters, most significant digit first
    iar_back #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (q_empty),
        .i_mag        (q_rdata[VALUE_WIDTH-1:0]),
        .i_flags      (back_flags),
        .o_pop        (q_pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_ascii_char (o_ascii_char),
        .o_last_char  (o_last_char)
    );

endmodule

`default_nettype wire
